FILE: hw/rtl/gft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gft_pkg: shared constants and types for the gimbal frame transform
// CORDIC arctangent table, formats and the data carried along the cell chain.
// ----------------------------------------------------------------------------
package gft_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_COUNT        = 24;
   localparam int ZW                = 36;   // angle accumulator, 2^-30 rad units
   localparam int CW                = 34;   // CORDIC x/y width
   localparam int PW                = 34;   // offset-added point width

   localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;

   localparam logic [2:0] CSR_X_OFFSET = 3'd0;
   localparam logic [2:0] CSR_Y_OFFSET = 3'd1;
   localparam logic [2:0] CSR_Z_OFFSET = 3'd2;

   function automatic logic signed [ZW-1:0] atan_q30(input int idx);
      logic signed [ZW-1:0] r;
      begin
         case (idx)
            0: r = 36'sd843314857;   1: r = 36'sd497837829;
            2: r = 36'sd263043837;   3: r = 36'sd133525159;
            4: r = 36'sd67021687;    5: r = 36'sd33543516;
            6: r = 36'sd16775851;    7: r = 36'sd8388437;
            8: r = 36'sd4194283;     9: r = 36'sd2097149;
            default: r = ZW'(36'sd1 <<< (30 - idx));
         endcase
         return r;
      end
   endfunction

   // one angle's CORDIC working set
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 neg;
   } rot_type;

   // transaction payload carried alongside the CORDIC cells
   typedef struct packed {
      logic                 mode;
      logic signed [PW-1:0] px;
      logic signed [PW-1:0] py;
      logic signed [PW-1:0] pz;
   } pt_type;

   typedef struct packed {
      rot_type pitch;
      rot_type yaw;
      pt_type  pt;
   } cell_type;

endpackage

FILE: hw/rtl/gft_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gft_cordic_cell: one CORDIC micro-rotation stage
// Rotates pitch and yaw vectors by atan(2^-STAGE), forwards the point.
// ----------------------------------------------------------------------------
module gft_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  gft_pkg::cell_type in_data,
   output logic              out_valid,
   output gft_pkg::cell_type out_data
);
   import gft_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

   function automatic rot_type step(input rot_type r);
      rot_type o;
      begin
         o = r;
         if (!r.z[ZW-1]) begin
            o.x = r.x - (r.y >>> STAGE);
            o.y = r.y + (r.x >>> STAGE);
            o.z = r.z - ATAN;
         end else begin
            o.x = r.x + (r.y >>> STAGE);
            o.y = r.y - (r.x >>> STAGE);
            o.z = r.z + ATAN;
         end
         return o;
      end
   endfunction

   cell_type data_ff;
   logic     valid_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (ce) valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         data_ff.pitch <= step(in_data.pitch);
         data_ff.yaw   <= step(in_data.yaw);
         data_ff.pt    <= in_data.pt;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: hw/rtl/gft_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gft_rotate: two-axis rotation back end
// Scales cos/sin, applies the two rotations in order, subtracts the offsets in inverse mode and saturates.
// ----------------------------------------------------------------------------
module gft_rotate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ce,
   input  logic                     in_valid,
   input  gft_pkg::cell_type        in_data,
   input  logic signed [31:0]       x_off,
   input  logic signed [31:0]       y_off,
   input  logic signed [31:0]       z_off,
   output logic                     out_valid,
   output logic signed [31:0]       out_x,
   output logic signed [31:0]       out_y,
   output logic signed [31:0]       out_z
);
   import gft_pkg::*;

   localparam int TW = 31;   // Q2.28 coefficient
   localparam int VW = 35;   // intermediate point, holds a rotated 33-bit vector

   function automatic logic signed [TW-1:0] trig_q28(input logic signed [CW-1:0] v,
                                                      input logic neg);
      logic signed [CW-1:0] t;
      logic signed [CW-1:0] r;
      begin
         t = neg ? -v : v;
         r = (t + CW'(2)) >>> 2;
         return TW'(r);
      end
   endfunction

   function automatic logic signed [VW-1:0] mac2(input logic signed [TW-1:0] a,
                                                  input logic signed [VW-1:0] p,
                                                  input logic signed [TW-1:0] b,
                                                  input logic signed [VW-1:0] q);
      logic signed [79:0] s;
      begin
         s = 80'(a) * 80'(p) + 80'(b) * 80'(q) + (80'sd1 <<< 27);
         return VW'(s >>> 28);
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
      begin
         if (v > VW'(64'sd2147483647)) return 32'sh7fffffff;
         if (v < -VW'(64'sd2147483648)) return 32'sh80000000;
         return v[31:0];
      end
   endfunction

   typedef struct packed {
      logic                 mode;
      logic signed [TW-1:0] cp, sp, cy, sy;
      logic signed [VW-1:0] x, y, z;
   } rs_type;

   rs_type s1_ff, s2_ff, s3_ff;
   rs_type s2_in, s3_in;
   logic   [3:0] v_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (ce) v_ff <= {v_ff[2:0], in_valid};
   end

   // rotation stages: first (pitch forward, yaw inverse), then second
   always_comb begin
      s2_in = s1_ff;
      if (!s1_ff.mode) begin
         s2_in.x = mac2(s1_ff.cp, s1_ff.x, s1_ff.sp, s1_ff.z);
         s2_in.z = mac2(-s1_ff.sp, s1_ff.x, s1_ff.cp, s1_ff.z);
      end else begin
         s2_in.x = mac2(s1_ff.cy, s1_ff.x, s1_ff.sy, s1_ff.y);
         s2_in.y = mac2(-s1_ff.sy, s1_ff.x, s1_ff.cy, s1_ff.y);
      end
      s3_in = s2_ff;
      if (!s2_ff.mode) begin
         s3_in.x = mac2(s2_ff.cy, s2_ff.x, -s2_ff.sy, s2_ff.y);
         s3_in.y = mac2(s2_ff.sy, s2_ff.x, s2_ff.cy, s2_ff.y);
      end else begin
         s3_in.x = mac2(s2_ff.cp, s2_ff.x, -s2_ff.sp, s2_ff.z);
         s3_in.z = mac2(s2_ff.sp, s2_ff.x, s2_ff.cp, s2_ff.z);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         // stage 1: coefficients
         s1_ff.mode <= in_data.pt.mode;
         s1_ff.cp   <= trig_q28(in_data.pitch.x, in_data.pitch.neg);
         s1_ff.sp   <= trig_q28(in_data.pitch.y, in_data.pitch.neg);
         s1_ff.cy   <= trig_q28(in_data.yaw.x, in_data.yaw.neg);
         s1_ff.sy   <= trig_q28(in_data.yaw.y, in_data.yaw.neg);
         s1_ff.x    <= VW'(in_data.pt.px);
         s1_ff.y    <= VW'(in_data.pt.py);
         s1_ff.z    <= VW'(in_data.pt.pz);
         // stages 2 and 3: the two rotations
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         // stage 4: inverse offset and saturation
         if (s3_ff.mode) begin
            ox_ff <= sat32(s3_ff.x - VW'(x_off));
            oy_ff <= sat32(s3_ff.y - VW'(y_off));
            oz_ff <= sat32(s3_ff.z - VW'(z_off));
         end else begin
            ox_ff <= sat32(s3_ff.x);
            oy_ff <= sat32(s3_ff.y);
            oz_ff <= sat32(s3_ff.z);
         end
      end
   end

   assign out_valid = v_ff[3];
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
endmodule

FILE: hw/rtl/gimbal_frame_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimbal_frame_transform: camera/gimbal frame point transform
// Offset plus pitch/yaw rotation with CORDIC-derived sine and cosine.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per clock unless back-pressure stalls it;
// the path is one input cell, a chain of min(CORDIC_STAGES, ATAN_COUNT)
// rotation cells that run pitch and yaw side by side, four rotation/saturation
// stages and one output register. The whole pipe advances whenever the output
// register is empty or being taken, so req_ready follows rsp_ready and
// back-pressure stalls every cell together. Offsets must be written while no
// transaction is in flight; forward mode uses them at entry, inverse mode just before saturation.
module gimbal_frame_transform #(
   parameter int CORDIC_STAGES = gft_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic signed [15:0] req_pitch,
   input  logic signed [15:0] req_yaw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import gft_pkg::*;

   localparam int NST = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

   logic signed [31:0] x_off_ff, y_off_ff, z_off_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff <= '0;
         y_off_ff <= '0;
         z_off_ff <= '0;
      end else if (csr_write) begin
         case ({1'b0, csr_index})
            CSR_X_OFFSET: x_off_ff <= csr_data;
            CSR_Y_OFFSET: y_off_ff <= csr_data;
            CSR_Z_OFFSET: z_off_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic ce;
   logic rsp_valid_ff;
   logic signed [31:0] rx_ff, ry_ff, rz_ff;
   assign ce        = !rsp_valid_ff || rsp_ready;
   assign req_ready = ce;

   // angle folding into the CORDIC range
   function automatic rot_type fold(input logic signed [15:0] a);
      rot_type r;
      logic signed [ZW-1:0] z;
      begin
         z = ZW'(a) <<< 17;
         r.x = GAIN_Q30;
         r.y = '0;
         r.neg = 1'b0;
         if (z > HALF_PI_Q30) begin
            z = z - PI_Q30; r.neg = 1'b1;
         end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30; r.neg = 1'b1;
         end
         r.z = z;
         return r;
      end
   endfunction

   cell_type head_ff;
   logic     head_v_ff;

   // input cell
   always_ff @(posedge clock) begin
      if (reset) head_v_ff <= 1'b0;
      else if (ce) head_v_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         head_ff.pitch   <= fold(req_pitch);
         head_ff.yaw     <= fold(req_yaw);
         head_ff.pt.mode <= req_mode;
         if (req_mode) begin
            head_ff.pt.px <= PW'(req_point_x);
            head_ff.pt.py <= PW'(req_point_y);
            head_ff.pt.pz <= PW'(req_point_z);
         end else begin
            head_ff.pt.px <= PW'(req_point_x) + PW'(x_off_ff);
            head_ff.pt.py <= PW'(req_point_y) + PW'(y_off_ff);
            head_ff.pt.pz <= PW'(req_point_z) + PW'(z_off_ff);
         end
      end
   end

   cell_type chain_d [NST+1];
   logic     chain_v [NST+1];
   assign chain_d[0] = head_ff;
   assign chain_v[0] = head_v_ff;

   // CORDIC cell chain
   for (genvar g = 0; g < NST; g++) begin : g_cell
      gft_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .ce(ce),
         .in_valid(chain_v[g]), .in_data(chain_d[g]),
         .out_valid(chain_v[g+1]), .out_data(chain_d[g+1])
      );
   end

   logic               rot_v;
   logic signed [31:0] rot_x, rot_y, rot_z;

   gft_rotate u_rotate (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(chain_v[NST]), .in_data(chain_d[NST]),
      .x_off(x_off_ff), .y_off(y_off_ff), .z_off(z_off_ff),
      .out_valid(rot_v), .out_x(rot_x), .out_y(rot_y), .out_z(rot_z)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (ce) rsp_valid_ff <= rot_v;
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rx_ff <= rot_x;
         ry_ff <= rot_y;
         rz_ff <= rot_z;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = rx_ff;
   assign rsp_out_y = ry_ff;
   assign rsp_out_z = rz_ff;

   // a stalled response holds its x and z data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_x) && $stable(rsp_out_z))
      else $error("response changed while stalled");
   // the pipe stalls only when the output is held by back-pressure
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline stalled without back-pressure");
   // an accepted request enters the head cell
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> head_v_ff)
      else $error("accepted request lost at entry");
endmodule
